// ===== sv/csd_pkg.sv =====
package csd_pkg;

  localparam int unsigned SP_W   = 32;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUB   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ZERO  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_APPLY = 3'd4;

  localparam logic [IDX_W-1:0] REG_HYST_UP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HYST_DOWN = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFS_HIGH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFS_LOW   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLP_HIGH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLP_LOW   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DAC_LIM   = 3'd6;
  localparam logic [IDX_W-1:0] REG_CEILING   = 3'd7;

  localparam logic [SP_W-1:0]   SLOPE_RST = 32'd65536;
  localparam logic [CODE_W-1:0] CODE_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SP_W-1:0]  amount;
    logic             mode_was_cc;
  } csd_in_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint;
    logic              dac_write;
    logic [CODE_W-1:0] dac_code;
    logic              range_high;
    logic              overload;
    logic              invalidate;
    logic [CODE_W-1:0] error_count;
  } csd_out_t;

  typedef struct packed {
    logic            start;
    logic [SP_W-1:0] dividend;
    logic [SP_W-1:0] divisor;
  } csd_div_req_t;

endpackage

// ===== sv/csd_div.sv =====
// radix-2 restoring divider, 16 quotient bits, dividend below divisor
module csd_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csd_pkg::csd_div_req_t req,
  output logic                 done,
  output logic [csd_pkg::CODE_W-1:0] quotient
);
  import csd_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SP_W-1:0]   rem_r, rem_nxt;
  logic [CODE_W-1:0] quo_r, quo_nxt;
  logic [SP_W-1:0]   dsr_r, dsr_nxt;
  logic [SP_W:0]     shifted;
  logic [SP_W:0]     diff;
  logic              ge;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(CODE_W - 1);
      rem_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so 32 bits always hold it
      rem_nxt = ge ? diff[SP_W-1:0] : shifted[SP_W-1:0];
      quo_nxt = {quo_r[CODE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/csd_regs.sv =====
module csd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [csd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csd_pkg::SP_W-1:0]    cfg_wdata,
  output logic [csd_pkg::SP_W-1:0]    hyst_up,
  output logic [csd_pkg::SP_W-1:0]    hyst_down,
  output logic [csd_pkg::SP_W-1:0]    ofs_high,
  output logic [csd_pkg::SP_W-1:0]    ofs_low,
  output logic [csd_pkg::SP_W-1:0]    slp_high,
  output logic [csd_pkg::SP_W-1:0]    slp_low,
  output logic [csd_pkg::CODE_W-1:0]  dac_lim,
  output logic [csd_pkg::SP_W-1:0]    ceiling
);
  import csd_pkg::*;

  logic [SP_W-1:0]   hyst_up_r, hyst_down_r, ofs_high_r, ofs_low_r;
  logic [SP_W-1:0]   slp_high_r, slp_low_r, ceiling_r;
  logic [CODE_W-1:0] dac_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_up_r   <= '0;
      hyst_down_r <= '0;
      ofs_high_r  <= '0;
      ofs_low_r   <= '0;
      slp_high_r  <= SLOPE_RST;
      slp_low_r   <= SLOPE_RST;
      dac_lim_r   <= CODE_MAX;
      ceiling_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HYST_UP:   hyst_up_r   <= cfg_wdata;
        REG_HYST_DOWN: hyst_down_r <= cfg_wdata;
        REG_OFS_HIGH:  ofs_high_r  <= cfg_wdata;
        REG_OFS_LOW:   ofs_low_r   <= cfg_wdata;
        REG_SLP_HIGH:  slp_high_r  <= cfg_wdata;
        REG_SLP_LOW:   slp_low_r   <= cfg_wdata;
        REG_DAC_LIM:   dac_lim_r   <= cfg_wdata[CODE_W-1:0];
        REG_CEILING:   ceiling_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign hyst_up   = hyst_up_r;
  assign hyst_down = hyst_down_r;
  assign ofs_high  = ofs_high_r;
  assign ofs_low   = ofs_low_r;
  assign slp_high  = slp_high_r;
  assign slp_low   = slp_low_r;
  assign dac_lim   = dac_lim_r;
  assign ceiling   = ceiling_r;

endmodule

// ===== sv/current_setpoint_to_dac_top.sv =====
// set, add, subtract, force zero and ignored codes go from accept through the execute and done states
// apply also passes through the divider state (16-step divider) unless the sum is non-positive or clamps early
// one request at a time; in_ready is low from accept until the result
// moves into the output register, which may still hold an untaken result meanwhile
// reset (rst_n, synchronous, active low) clears setpoint, range and error count and restores config defaults
module current_setpoint_to_dac_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  csd_pkg::csd_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output csd_pkg::csd_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [csd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csd_pkg::SP_W-1:0]    cfg_wdata
);
  import csd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [SP_W-1:0]   hyst_up, hyst_down, ofs_high, ofs_low, slp_high, slp_low, ceiling;
  logic [CODE_W-1:0] dac_lim;

  csd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .hyst_up   (hyst_up),
    .hyst_down (hyst_down),
    .ofs_high  (ofs_high),
    .ofs_low   (ofs_low),
    .slp_high  (slp_high),
    .slp_low   (slp_low),
    .dac_lim   (dac_lim),
    .ceiling   (ceiling)
  );

  logic [1:0]        state_r, state_nxt;
  csd_in_t           req_r, req_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              rng_r, rng_nxt;
  logic [CODE_W-1:0] err_r, err_nxt;
  logic              wr_r, wr_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              ovl_r, ovl_nxt;
  logic              inval_r, inval_nxt;
  logic              out_valid_r, out_valid_nxt;
  csd_out_t          out_data_r, out_data_nxt;

  csd_div_req_t      div_req;
  logic              div_done;
  logic [CODE_W-1:0] div_quo;

  csd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic [SP_W:0]     add_sum;
  logic              rng_sel;
  logic [SP_W-1:0]   ofs_sel, slp_sel;
  logic [SP_W+1:0]   sum;
  logic              sum_pos, sum_big;

  assign add_sum = {1'b0, sp_r} + {1'b0, req_r.amount};

  always_comb begin
    priority if (sp_r == '0)      rng_sel = 1'b0;
    else if (sp_r > hyst_up)      rng_sel = 1'b1;
    else if (sp_r < hyst_down)    rng_sel = 1'b0;
    else                          rng_sel = rng_r;
  end

  assign ofs_sel = rng_sel ? ofs_high : ofs_low;
  assign slp_sel = rng_sel ? slp_high : slp_low;
  assign sum     = {2'b00, sp_r} + {{2{ofs_sel[SP_W-1]}}, ofs_sel};
  // a zero setpoint always writes code 0 whatever the offset
  assign sum_pos = (sp_r != '0) && !sum[SP_W+1] && (sum != '0);
  // quotient reaches 65536 exactly when sum >= slope, also covers zero slope
  assign sum_big = sum[SP_W:0] >= {1'b0, slp_sel};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    sp_nxt        = sp_r;
    rng_nxt       = rng_r;
    err_nxt       = err_r;
    wr_nxt        = wr_r;
    code_nxt      = code_r;
    ovl_nxt       = ovl_r;
    inval_nxt     = inval_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = sum[SP_W-1:0];
    div_req.divisor  = slp_sel;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        wr_nxt    = 1'b0;
        code_nxt  = '0;
        ovl_nxt   = 1'b0;
        inval_nxt = 1'b0;
        state_nxt = S_DONE;
        unique case (req_r.req_type)
          REQ_SET: sp_nxt = req_r.amount;
          REQ_ADD: sp_nxt = add_sum[SP_W] ? ceiling : add_sum[SP_W-1:0];
          REQ_SUB: sp_nxt = (req_r.amount > sp_r) ? '0 : sp_r - req_r.amount;
          REQ_ZERO: begin
            sp_nxt = '0;
            wr_nxt = 1'b1;
          end
          REQ_APPLY: begin
            wr_nxt    = 1'b1;
            rng_nxt   = rng_sel;
            inval_nxt = (rng_sel != rng_r) || !req_r.mode_was_cc;
            if (sum_pos) begin
              if (sum_big) begin
                code_nxt = dac_lim;
                if (rng_sel) begin
                  ovl_nxt = 1'b1;
                  err_nxt = err_r + 1'b1;
                end
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
          if (div_quo > dac_lim) begin
            code_nxt = dac_lim;
            if (rng_r) begin
              ovl_nxt = 1'b1;
              err_nxt = err_r + 1'b1;
            end
          end else begin
            code_nxt = div_quo;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.setpoint    = sp_r;
          out_data_nxt.dac_write   = wr_r;
          out_data_nxt.dac_code    = code_r;
          out_data_nxt.range_high  = rng_r;
          out_data_nxt.overload    = ovl_r;
          out_data_nxt.invalidate  = inval_r;
          out_data_nxt.error_count = err_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      rng_r       <= 1'b0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      rng_r       <= rng_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    wr_r       <= wr_nxt;
    code_r     <= code_nxt;
    ovl_r      <= ovl_nxt;
    inval_r    <= inval_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/csd_checker.sv =====
module csd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input csd_pkg::csd_in_t           in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input csd_pkg::csd_out_t          out_data,
  input logic                       cfg_we,
  input logic [csd_pkg::IDX_W-1:0]  cfg_index,
  input logic [csd_pkg::SP_W-1:0]   cfg_wdata
);
  import csd_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_data, cfg_we, cfg_index, cfg_wdata};

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dac_write |-> out_data.dac_code == '0)
    else $error("nonzero code without dac write");

  a_ovl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overload |-> out_data.dac_write && out_data.range_high)
    else $error("overload outside high-range apply");

endmodule

bind current_setpoint_to_dac_top csd_checker u_csd_checker (.*);
